>>> src/iira_pkg.sv
`default_nettype none
package iira_pkg;

    localparam int CAPACITY   = 16;
    localparam int CNT_W      = $clog2(CAPACITY + 1);
    localparam int CIDX_W     = $clog2(CAPACITY);

    // fixed field widths of the stream items
    localparam int ACTION_W   = 3;
    localparam int POS_W      = 5;
    localparam int WORD_W     = 32;
    localparam int STATUS_W   = 2;
    localparam int CNT_FLD_W  = 5;
    localparam int EIDX_W     = 4;
    localparam int CMP_W      = (CNT_W > POS_W) ? CNT_W : POS_W;

    localparam int IN_BITS    = ACTION_W + POS_W + WORD_W;
    localparam int IN_TDATA_W = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS   = STATUS_W + CNT_FLD_W + WORD_W + EIDX_W;
    localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

    typedef logic [CNT_W-1:0]        t_count;
    typedef logic [CIDX_W-1:0]       t_cidx;
    typedef logic [CMP_W-1:0]        t_cmp;
    typedef logic [POS_W-1:0]        t_pos;
    typedef logic signed [WORD_W-1:0] t_word;
    typedef logic [CNT_FLD_W-1:0]    t_cnt_fld;
    typedef logic [EIDX_W-1:0]       t_eidx;

    typedef enum logic [ACTION_W-1:0] {
        ACT_PUSH       = 3'd0,
        ACT_POP        = 3'd1,
        ACT_INSERT_AT  = 3'd2,
        ACT_REMOVE_AT  = 3'd3,
        ACT_INSERT_MID = 3'd4,
        ACT_REMOVE_MID = 3'd5,
        ACT_DUMP       = 3'd6
    } t_action;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_RANGE = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        CELL_HOLD       = 3'd0,
        CELL_LOAD       = 3'd1,
        CELL_FROM_LEFT  = 3'd2,
        CELL_FROM_RIGHT = 3'd3,
        CELL_FROM_FIRST = 3'd4
    } t_cell_op;

    // lowest field in the lowest bits
    typedef struct packed {
        t_word                 item_value;
        t_pos                  position;
        logic [ACTION_W-1:0]   action;
    } t_in_item;

    typedef struct packed {
        t_eidx                 element_index;
        t_word                 element;
        t_cnt_fld              count_after;
        logic [STATUS_W-1:0]   status;
    } t_out_data;

    typedef struct packed {
        logic      last;
        t_out_data data;
    } t_out_item;

endpackage
`default_nettype wire

>>> src/iira_cell.sv
`default_nettype none
module iira_cell (
    input  wire                  i_clk,
    input  iira_pkg::t_cell_op   i_op,
    input  iira_pkg::t_word      i_left,
    input  iira_pkg::t_word      i_right,
    input  iira_pkg::t_word      i_first,
    input  iira_pkg::t_word      i_value,
    output iira_pkg::t_word      o_data
);

    iira_pkg::t_word r_data;
    iira_pkg::t_word n_data;

    always_comb begin
        unique case (i_op)
            iira_pkg::CELL_LOAD:       n_data = i_value;
            iira_pkg::CELL_FROM_LEFT:  n_data = i_left;
            iira_pkg::CELL_FROM_RIGHT: n_data = i_right;
            iira_pkg::CELL_FROM_FIRST: n_data = i_first;
            default:                   n_data = r_data;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule
`default_nettype wire

>>> src/iira_out_fifo.sv
`default_nettype none
module iira_out_fifo (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_push,
    input  iira_pkg::t_out_item  i_item,
    output logic                 o_full,
    output logic                 o_valid,
    input  wire                  i_ready,
    output iira_pkg::t_out_item  o_item
);

    iira_pkg::t_out_item r_q [2];
    logic                r_wp;
    logic                r_rp;
    logic [1:0]          r_cnt;
    logic [1:0]          n_cnt;
    logic                pop;

    assign pop     = o_valid && i_ready;
    assign o_valid = (r_cnt != 2'd0);
    assign o_full  = (r_cnt == 2'd2);
    assign o_item  = r_q[r_rp];

    always_comb begin
        n_cnt = r_cnt;
        if (i_push && !pop) begin
            n_cnt = r_cnt + 2'd1;
        end else if (!i_push && pop) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (pop) begin
                r_rp <= ~r_rp;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_q[r_wp] <= i_item;
        end
    end

endmodule
`default_nettype wire

>>> src/indexed_insert_remove_array_top.sv
// ordered array of up to 16 signed 32-bit words, kept in a row of cells
// input stream: one action per item (push, pop, insert at, remove at,
//   insert middle, remove middle, dump); tdata holds action, position,
//   item_value from the lowest bit up
// output stream: status, count_after, element, element_index in tdata,
//   last in tlast
// every accepted action but dump that has status ok changes the row in the
//   cycle it is accepted, each cell taking its own word, its left or right
//   neighbor or the new word; its result goes into the output queue
// with the output flowing and no dump running, one action is accepted every cycle
// dump rotates the stored words through cell 0, one result per cycle after
//   the accept while the output queue is not full; a dump of an empty array
//   does not run, and no item is accepted while a dump runs
// a two-item output queue sits between the sides; input ready drops only
//   when it is full or a dump is running, so a stalled receiver holds the
//   block after at most two results
// reset (synchronous, active low) empties the array and the output queue;
//   the cell contents are not cleared
`default_nettype none
module indexed_insert_remove_array_top (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 s_axis_tvalid,
    output logic                                s_axis_tready,
    // action[2:0], position[7:3], item_value[39:8]
    input  wire  [iira_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    output logic                                m_axis_tvalid,
    input  wire                                 m_axis_tready,
    // status[1:0], count_after[6:2], element[38:7], element_index[42:39]
    output logic [iira_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    output logic                                m_axis_tlast
);

    iira_pkg::t_in_item   in_item;
    iira_pkg::t_count     r_count;
    iira_pkg::t_count     n_count;
    logic                 r_dump;
    iira_pkg::t_cidx      r_didx;
    logic                 in_acc;
    logic                 q_full;
    logic                 dump_step;
    logic                 dump_last;
    logic                 is_ins;
    logic                 is_rem;
    logic                 commit_ins;
    logic                 commit_rem;
    iira_pkg::t_cmp       pos_cmp;
    iira_pkg::t_cmp       cnt_cmp;
    iira_pkg::t_count     pos;
    iira_pkg::t_status    status;
    logic                 q_push;
    iira_pkg::t_out_item  q_item;
    iira_pkg::t_out_item  q_head;
    iira_pkg::t_cell_op   cell_op   [iira_pkg::CAPACITY];
    iira_pkg::t_word      cell_data [iira_pkg::CAPACITY];

    assign in_item       = iira_pkg::t_in_item'(s_axis_tdata[iira_pkg::IN_BITS-1:0]);
    assign s_axis_tready = !r_dump && !q_full;
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign dump_step     = r_dump && !q_full;
    assign dump_last     = (iira_pkg::t_count'(r_didx) == r_count - 1'b1);
    assign cnt_cmp       = iira_pkg::t_cmp'(r_count);

    // action decode and status
    always_comb begin
        is_ins  = 1'b0;
        is_rem  = 1'b0;
        pos_cmp = cnt_cmp;
        unique case (iira_pkg::t_action'(in_item.action))
            iira_pkg::ACT_PUSH: begin
                is_ins  = 1'b1;
            end
            iira_pkg::ACT_POP: begin
                is_rem  = 1'b1;
                pos_cmp = cnt_cmp - 1'b1;
            end
            iira_pkg::ACT_INSERT_AT: begin
                is_ins  = 1'b1;
                pos_cmp = iira_pkg::t_cmp'(in_item.position);
            end
            iira_pkg::ACT_REMOVE_AT: begin
                is_rem  = 1'b1;
                pos_cmp = iira_pkg::t_cmp'(in_item.position);
            end
            iira_pkg::ACT_INSERT_MID: begin
                is_ins  = 1'b1;
                pos_cmp = cnt_cmp >> 1;
            end
            iira_pkg::ACT_REMOVE_MID: begin
                is_rem  = 1'b1;
                pos_cmp = cnt_cmp >> 1;
            end
            default: begin
                pos_cmp = cnt_cmp;
            end
        endcase

        status = iira_pkg::ST_OK;
        if (is_ins) begin
            if (r_count == iira_pkg::t_count'(iira_pkg::CAPACITY)) begin
                status = iira_pkg::ST_FULL;
            end else if (pos_cmp > cnt_cmp) begin
                status = iira_pkg::ST_RANGE;
            end
        end else if (is_rem) begin
            if (r_count == '0) begin
                status = iira_pkg::ST_EMPTY;
            end else if (pos_cmp >= cnt_cmp) begin
                status = iira_pkg::ST_RANGE;
            end
        end else if (iira_pkg::t_action'(in_item.action) == iira_pkg::ACT_DUMP &&
                     r_count == '0) begin
            status = iira_pkg::ST_EMPTY;
        end
    end

    // position is only used once it has been checked against the count
    assign pos        = iira_pkg::t_count'(pos_cmp);
    assign commit_ins = in_acc && is_ins && (status == iira_pkg::ST_OK);
    assign commit_rem = in_acc && is_rem && (status == iira_pkg::ST_OK);

    always_comb begin
        n_count = r_count;
        if (commit_ins) begin
            n_count = r_count + 1'b1;
        end else if (commit_rem) begin
            n_count = r_count - 1'b1;
        end
    end

    // per-cell select
    always_comb begin
        for (int i = 0; i < iira_pkg::CAPACITY; i++) begin
            cell_op[i] = iira_pkg::CELL_HOLD;
            if (dump_step) begin
                if (iira_pkg::t_count'(i) + 1'b1 < r_count) begin
                    cell_op[i] = iira_pkg::CELL_FROM_RIGHT;
                end else if (iira_pkg::t_count'(i) + 1'b1 == r_count) begin
                    cell_op[i] = iira_pkg::CELL_FROM_FIRST;
                end
            end else if (commit_ins) begin
                if (iira_pkg::t_count'(i) == pos) begin
                    cell_op[i] = iira_pkg::CELL_LOAD;
                end else if (iira_pkg::t_count'(i) > pos &&
                             iira_pkg::t_count'(i) <= r_count) begin
                    cell_op[i] = iira_pkg::CELL_FROM_LEFT;
                end
            end else if (commit_rem) begin
                if (iira_pkg::t_count'(i) >= pos &&
                    iira_pkg::t_count'(i) + 1'b1 < r_count) begin
                    cell_op[i] = iira_pkg::CELL_FROM_RIGHT;
                end
            end
        end
    end

    for (genvar g = 0; g < iira_pkg::CAPACITY; g++) begin : g_cell
        iira_cell u_cell (
            .i_clk   (i_clk),
            .i_op    (cell_op[g]),
            .i_left  ((g == 0) ? iira_pkg::t_word'(0) : cell_data[(g == 0) ? 0 : g - 1]),
            .i_right ((g == iira_pkg::CAPACITY - 1) ? iira_pkg::t_word'(0) :
                      cell_data[(g == iira_pkg::CAPACITY - 1) ? g : g + 1]),
            .i_first (cell_data[0]),
            .i_value (in_item.item_value),
            .o_data  (cell_data[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_dump  <= 1'b0;
            r_didx  <= '0;
        end else begin
            r_count <= n_count;
            if (in_acc && iira_pkg::t_action'(in_item.action) == iira_pkg::ACT_DUMP &&
                r_count != '0) begin
                r_dump <= 1'b1;
                r_didx <= '0;
            end else if (dump_step) begin
                r_didx <= r_didx + 1'b1;
                if (dump_last) begin
                    r_dump <= 1'b0;
                end
            end
        end
    end

    // result to the output queue
    always_comb begin
        q_push = in_acc || dump_step;
        if (dump_step) begin
            q_item.last               = dump_last;
            q_item.data.status        = iira_pkg::ST_OK;
            q_item.data.count_after   = iira_pkg::t_cnt_fld'(r_count);
            q_item.data.element       = cell_data[0];
            q_item.data.element_index = iira_pkg::t_eidx'(r_didx);
        end else begin
            q_item.last               = !(iira_pkg::t_action'(in_item.action) ==
                                          iira_pkg::ACT_DUMP && r_count != '0);
            q_item.data.status        = status;
            q_item.data.count_after   = iira_pkg::t_cnt_fld'(n_count);
            q_item.data.element       = '0;
            q_item.data.element_index = '0;
        end
    end

    // a non-empty dump queues nothing on accept: its results come from the steps
    iira_out_fifo u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push && q_item.last | dump_step),
        .i_item  (q_item),
        .o_full  (q_full),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_item  (q_head)
    );

    assign m_axis_tdata = {{(iira_pkg::OUT_TDATA_W - iira_pkg::OUT_BITS){1'b0}}, q_head.data};
    assign m_axis_tlast = q_head.last;

endmodule
`default_nettype wire

>>> src/iira_checker.sv
`default_nettype none
module iira_checker (
    input wire                               i_clk,
    input wire                               i_rst_n,
    input wire                               s_axis_tvalid,
    input wire                               s_axis_tready,
    input wire [iira_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    input wire                               m_axis_tvalid,
    input wire                               m_axis_tready,
    input wire [iira_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
    input wire                               m_axis_tlast
);

    iira_pkg::t_out_data od;
    assign od = iira_pkg::t_out_data'(m_axis_tdata[iira_pkg::OUT_BITS-1:0]);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("output item changed while stalled");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> od.count_after <= iira_pkg::t_cnt_fld'(iira_pkg::CAPACITY))
        else $error("count above capacity");

    // only a dump gives results that are not the last one
    a_mid_dump_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tlast |-> od.status == iira_pkg::ST_OK &&
            od.count_after != '0)
        else $error("non-final result outside a dump");

    a_err_no_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && od.status != iira_pkg::ST_OK |->
            od.element == '0 && od.element_index == '0 && m_axis_tlast)
        else $error("error result carries data");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid right after reset");

endmodule

bind indexed_insert_remove_array_top iira_checker u_iira_checker (.*);
`default_nettype wire
